FILE: src/rmc_pkg.sv
// Shared types, constants and helpers for the cube ray-march core.
`default_nettype none

package rmc_pkg;

    localparam int POS_W   = 32;
    localparam int DIR_W   = 18;
    localparam int COEF_W  = 16;
    localparam int STEP_W  = 8;
    localparam int COEF_BITS = 16;
    localparam int PROD_W  = DIR_W + POS_W;
    localparam int SAT_W   = PROD_W + 1;
    localparam int IDX_W   = 2;

    localparam logic [STEP_W-1:0] MAX_STEPS_RST = 8'd100;
    localparam logic [IDX_W-1:0]  IDX_PIX = 2'd3;

    localparam logic signed [SAT_W-1:0] S32_MAX = SAT_W'(64'sd2147483647);
    localparam logic signed [SAT_W-1:0] S32_MIN = -SAT_W'(64'sd2147483648);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BOUND,
        ST_EVAL,
        ST_MUL,
        ST_DRAIN,
        ST_DONE
    } rmc_state_t;

    typedef struct packed {
        logic             busy;
        logic             bound_en;
        logic             eval_en;
        logic             mul_en;
        logic [IDX_W-1:0] mul_idx;
        logic             step_inc;
        logic             res_load;
    } rmc_ctrl_t;

    typedef struct packed {
        logic in_take;
        logic limit_hit;
        logic eval_end;
        logic out_free;
    } rmc_stat_t;

    function automatic logic signed [POS_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > S32_MAX)
        begin
            r = S32_MAX[POS_W-1:0];
        end
        else if (v < S32_MIN)
        begin
            r = S32_MIN[POS_W-1:0];
        end
        else
        begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: src/rmc_mul.sv
// Shared multiply unit: registered signed product with floor shift on the output.
`default_nettype none

module rmc_mul
    import rmc_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     en,
    input  wire logic                     sel_coef,
    input  wire logic [IDX_W-1:0]         tag_in,
    input  wire logic signed [DIR_W-1:0]  op_a,
    input  wire logic signed [POS_W-1:0]  op_b,
    output logic                          vld,
    output logic [IDX_W-1:0]              tag,
    output logic signed [PROD_W-1:0]      res
);

    logic signed [PROD_W-1:0] prod_reg;
    logic                     sel_reg;
    logic [IDX_W-1:0]         tag_reg;
    logic                     vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
            sel_reg  <= sel_coef;
            tag_reg  <= tag_in;
        end
    end

    assign res = sel_reg ? (prod_reg >>> COEF_BITS) : (prod_reg >>> FRAC_BITS);
    assign vld = vld_reg;
    assign tag = tag_reg;

endmodule

`default_nettype wire

FILE: src/rmc_ctrl.sv
// Sequencer for the ray-march iteration: bound, evaluate, four multiplies, drain.
`default_nettype none

module rmc_ctrl
    import rmc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire rmc_stat_t stat,
    output rmc_ctrl_t      ctrl
);

    rmc_state_t       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (stat.in_take)
                begin
                    state_next = ST_BOUND;
                end
            end
            ST_BOUND:
            begin
                state_next = stat.limit_hit ? ST_DONE : ST_EVAL;
            end
            ST_EVAL:
            begin
                state_next = stat.eval_end ? ST_DONE : ST_MUL;
            end
            ST_MUL:
            begin
                if (idx_reg == IDX_PIX)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_BOUND;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl          = '0;
        ctrl.busy     = (state_reg != ST_IDLE);
        ctrl.mul_idx  = idx_reg;
        unique case (state_reg)
            ST_IDLE:  ctrl.busy     = 1'b0;
            ST_BOUND: ctrl.bound_en = 1'b1;
            ST_EVAL:  ctrl.eval_en  = 1'b1;
            ST_MUL:   ctrl.mul_en   = 1'b1;
            ST_DRAIN: ctrl.step_inc = 1'b1;
            ST_DONE:  ctrl.res_load = stat.out_free;
            default:  ctrl.busy     = 1'b1;
        endcase
    end

`ifndef SYNTH
    a_mul_four: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> ($past(state_reg) == ST_MUL && $past(idx_reg) == IDX_PIX))
        else $error("drain without full multiply pass");
    a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_MUL) |-> (idx_reg == '0))
        else $error("multiply index not cleared");
    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !stat.out_free) |=> (state_reg == ST_DONE))
        else $error("result dropped while output full");
`endif

endmodule

`default_nettype wire

FILE: src/cube_sphere_trace_raymarch_core.sv
// Top level: ray register file, bound and distance evaluation, result register.
`default_nettype none

// Sphere-traces one ray against the unit cube in signed fixed point and returns one
// result word per ray. Each march iteration runs a bound check, a distance estimate,
// four passes through the one shared multiplier and a final add. A ray ends by the
// bound or hit test, or by running into the step limit, the longest case. The core
// returns to idle before the next ray is taken, and the done state lasts longer while
// a waiting result blocks it.
// in_stall is high from acceptance until the result is placed in the output register;
// the output register lets the next ray enter while a result waits. max_steps may be
// written only while idle.

module cube_sphere_trace_raymarch_core
    import rmc_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_wr_en,
    input  wire logic [STEP_W-1:0]         cfg_wr_data,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic signed [POS_W-1:0]   origin_x,
    input  wire logic signed [POS_W-1:0]   origin_y,
    input  wire logic signed [POS_W-1:0]   origin_z,
    input  wire logic signed [DIR_W-1:0]   dir_x,
    input  wire logic signed [DIR_W-1:0]   dir_y,
    input  wire logic signed [DIR_W-1:0]   dir_z,
    input  wire logic [COEF_W-1:0]         spread_coef,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic                           hit,
    output logic [STEP_W-1:0]              steps_taken,
    output logic signed [POS_W-1:0]        travel_dist,
    output logic                           limit_reached
);

    localparam int DE_W = POS_W + 3;
    localparam logic [POS_W-1:0] ONE = POS_W'(64'd1 << FRAC_BITS);

    rmc_ctrl_t ctrl;
    rmc_stat_t stat;

    logic [STEP_W-1:0]        max_steps_reg;
    logic signed [POS_W-1:0]  px_reg [3];
    logic signed [DIR_W-1:0]  dx_reg [3];
    logic [COEF_W-1:0]        coef_reg;
    logic signed [POS_W-1:0]  pix_reg;
    logic signed [POS_W-1:0]  dist_reg;
    logic signed [POS_W-1:0]  de_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [POS_W-1:0]         mx_reg;
    logic                     outside_reg;
    logic                     fin_hit_reg;
    logic                     fin_lim_reg;

    logic                     out_valid_reg;
    logic                     hit_reg;
    logic [STEP_W-1:0]        steps_reg;
    logic signed [POS_W-1:0]  travel_reg;
    logic                     lim_reg;

    logic                     in_take;
    logic [POS_W-1:0]         abs_p [3];
    logic [POS_W-1:0]         mx;
    logic                     same;
    logic signed [DE_W-1:0]   de_wide;
    logic signed [POS_W-1:0]  de;
    logic signed [POS_W:0]    de_ext;
    logic [POS_W:0]           abs_de;
    logic                     hit_cond;

    logic signed [DIR_W-1:0]  mul_a;
    logic                     mul_sel;
    logic                     mv;
    logic [IDX_W-1:0]         mtag;
    logic signed [PROD_W-1:0] mres;
    logic signed [POS_W-1:0]  add_tgt;
    logic signed [POS_W-1:0]  add_sum;

    assign in_take  = in_valid && !in_stall;
    assign in_stall = ctrl.busy;

    // bound check
    always_comb
    begin
        logic signed [POS_W:0] pe;
        same = 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            pe       = {px_reg[k][POS_W-1], px_reg[k]};
            abs_p[k] = pe[POS_W] ? POS_W'(-pe) : POS_W'(pe);
            if (px_reg[k][POS_W-1] != dx_reg[k][DIR_W-1])
            begin
                same = 1'b0;
            end
        end
        mx = (abs_p[0] > abs_p[1]) ? abs_p[0] : abs_p[1];
        mx = (abs_p[2] > mx) ? abs_p[2] : mx;
    end

    // distance estimate and hit test
    always_comb
    begin
        de_wide  = $signed({3'b000, mx_reg}) - $signed({3'b000, ONE})
                   - DE_W'(pix_reg);
        de       = sat32(SAT_W'(de_wide));
        de_ext   = {de[POS_W-1], de};
        abs_de   = de_ext[POS_W] ? (POS_W+1)'(-de_ext) : (POS_W+1)'(de_ext);
        hit_cond = ($signed({1'b0, abs_de, 1'b0}) <= (POS_W+3)'(pix_reg))
                   || ((de[POS_W-1] || de == '0) && step_reg == '0);
    end

    assign stat.in_take   = in_take;
    assign stat.limit_hit = (step_reg == max_steps_reg);
    assign stat.eval_end  = outside_reg || hit_cond;
    assign stat.out_free  = !out_valid_reg || !out_stall;

    rmc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    always_comb
    begin
        mul_sel = 1'b0;
        unique case (ctrl.mul_idx)
            2'd0:    mul_a = dx_reg[0];
            2'd1:    mul_a = dx_reg[1];
            2'd2:    mul_a = dx_reg[2];
            default:
            begin
                mul_a   = DIR_W'({1'b0, coef_reg});
                mul_sel = 1'b1;
            end
        endcase
    end

    rmc_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (ctrl.mul_en),
        .sel_coef (mul_sel),
        .tag_in   (ctrl.mul_idx),
        .op_a     (mul_a),
        .op_b     (de_reg),
        .vld      (mv),
        .tag      (mtag),
        .res      (mres)
    );

    always_comb
    begin
        unique case (mtag)
            2'd0:    add_tgt = px_reg[0];
            2'd1:    add_tgt = px_reg[1];
            2'd2:    add_tgt = px_reg[2];
            default: add_tgt = pix_reg;
        endcase
        add_sum = sat32(SAT_W'(add_tgt) + SAT_W'(mres));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_steps_reg <= MAX_STEPS_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_steps_reg <= cfg_wr_data;
            end
            if (ctrl.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            px_reg[0] <= origin_x;
            px_reg[1] <= origin_y;
            px_reg[2] <= origin_z;
            dx_reg[0] <= dir_x;
            dx_reg[1] <= dir_y;
            dx_reg[2] <= dir_z;
            coef_reg  <= spread_coef;
            pix_reg   <= '0;
            dist_reg  <= '0;
            step_reg  <= '0;
        end
        else
        begin
            if (mv)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (mtag == IDX_W'(k))
                    begin
                        px_reg[k] <= add_sum;
                    end
                end
                if (mtag == IDX_PIX)
                begin
                    pix_reg <= add_sum;
                end
            end
            if (ctrl.step_inc)
            begin
                step_reg <= step_reg + 1'b1;
            end
            if (ctrl.eval_en && !stat.eval_end)
            begin
                dist_reg <= sat32(SAT_W'(dist_reg) + SAT_W'(de));
                de_reg   <= de;
            end
        end

        if (ctrl.bound_en)
        begin
            mx_reg      <= mx;
            outside_reg <= (mx > ONE) && same;
            fin_hit_reg <= 1'b1;
            fin_lim_reg <= 1'b1;
        end
        if (ctrl.eval_en)
        begin
            fin_hit_reg <= !outside_reg;
            fin_lim_reg <= 1'b0;
        end

        if (ctrl.res_load)
        begin
            hit_reg    <= fin_hit_reg;
            steps_reg  <= step_reg;
            travel_reg <= dist_reg;
            lim_reg    <= fin_lim_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign steps_taken   = steps_reg;
    assign travel_dist   = travel_reg;
    assign limit_reached = lim_reg;

`ifndef SYNTH
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (ctrl.bound_en && step_reg == '0))
        else $error("ray did not start at iteration zero");
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.busy |-> (step_reg <= max_steps_reg))
        else $error("iteration count beyond limit");
    a_limit_is_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && limit_reached) |-> (hit && steps_taken == max_steps_reg))
        else $error("limit result inconsistent");
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.res_load |=> out_valid)
        else $error("result load lost");
`endif

endmodule

`default_nettype wire

FILE: dv/cube_sphere_trace_raymarch_core_tb.sv
// Self-checking testbench for the cube ray-march core, with directed and random rays.
`timescale 1ns / 1ps

module cube_sphere_trace_raymarch_core_tb
    import rmc_pkg::*;
();

    localparam int     FRAC_BITS = 16;
    localparam longint Q_ONE = longint'(1) << FRAC_BITS;
    localparam longint Q_HI = 64'sd2147483647;
    localparam longint Q_LO = -64'sd2147483648;
    localparam int     P_MAX = 32'h7FFFFFFF;
    localparam int     P_MIN = 32'h80000000;
    localparam int     MARCH_CYCLES_MAX = 7 * 255 + 3;
    localparam int     WATCHDOG_LIMIT = 8 * MARCH_CYCLES_MAX;

    typedef struct {
        logic signed [POS_W-1:0] ox;
        logic signed [POS_W-1:0] oy;
        logic signed [POS_W-1:0] oz;
        logic signed [DIR_W-1:0] dx;
        logic signed [DIR_W-1:0] dy;
        logic signed [DIR_W-1:0] dz;
        logic [COEF_W-1:0]       spread;
    } ray_t;

    typedef struct {
        logic                    hit;
        logic [STEP_W-1:0]       steps;
        logic signed [POS_W-1:0] travel;
        logic                    limit_flag;
    } march_res_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_wr_en;
    logic [STEP_W-1:0]       cfg_wr_data;
    logic                    in_valid;
    logic                    in_stall;
    logic signed [POS_W-1:0] origin_x;
    logic signed [POS_W-1:0] origin_y;
    logic signed [POS_W-1:0] origin_z;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
    logic [COEF_W-1:0]       spread_coef;
    logic                    out_valid;
    logic                    out_stall;
    logic                    hit;
    logic [STEP_W-1:0]       steps_taken;
    logic signed [POS_W-1:0] travel_dist;
    logic                    limit_reached;

    march_res_t        march_expect[$];
    march_res_t        want_res;
    logic [STEP_W-1:0] cfg_max_steps = MAX_STEPS_RST;
    int                mismatch_count = 0;
    int                results_seen = 0;
    int                quiet_cycles = 0;
    int                cycle_cnt = 0;
    int                stall_mode = 0;
    int                stall_hold = 0;
    int                gap_max = 0;
    int                burst_left = 0;

    cube_sphere_trace_raymarch_core #(
        .FRAC_BITS(FRAC_BITS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .origin_x(origin_x),
        .origin_y(origin_y),
        .origin_z(origin_z),
        .dir_x(dir_x),
        .dir_y(dir_y),
        .dir_z(dir_z),
        .spread_coef(spread_coef),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .hit(hit),
        .steps_taken(steps_taken),
        .travel_dist(travel_dist),
        .limit_reached(limit_reached)
    );

    always #1 clk = ~clk;

    function automatic longint clamp_s32(input longint v);
        if (v > Q_HI)
        begin
            return Q_HI;
        end
        if (v < Q_LO)
        begin
            return Q_LO;
        end
        return v;
    endfunction

    function automatic march_res_t predict_march(input ray_t r, input logic [STEP_W-1:0] steps_max);
        longint     pos[3];
        longint     dir[3];
        longint     pix;
        longint     trav;
        longint     mx;
        longint     de;
        longint     mag;
        bit         same_side;
        march_res_t res;
        pos[0] = r.ox;
        pos[1] = r.oy;
        pos[2] = r.oz;
        dir[0] = r.dx;
        dir[1] = r.dy;
        dir[2] = r.dz;
        pix = 0;
        trav = 0;
        for (int i = 0; i < int'(steps_max); i++)
        begin
            mx = 0;
            same_side = 1'b1;
            for (int k = 0; k < 3; k++)
            begin
                mag = (pos[k] < 0) ? -pos[k] : pos[k];
                if (mag > mx)
                begin
                    mx = mag;
                end
                if ((pos[k] < 0) != (dir[k] < 0))
                begin
                    same_side = 1'b0;
                end
            end
            if (mx > Q_ONE && same_side)
            begin
                res.hit = 1'b0;
                res.steps = STEP_W'(i);
                res.travel = trav[POS_W-1:0];
                res.limit_flag = 1'b0;
                return res;
            end
            de = clamp_s32(mx - Q_ONE - pix);
            if (2 * ((de < 0) ? -de : de) <= pix || (de <= 0 && i == 0))
            begin
                res.hit = 1'b1;
                res.steps = STEP_W'(i);
                res.travel = trav[POS_W-1:0];
                res.limit_flag = 1'b0;
                return res;
            end
            trav = clamp_s32(trav + de);
            for (int k = 0; k < 3; k++)
            begin
                pos[k] = clamp_s32(pos[k] + ((dir[k] * de) >>> FRAC_BITS));
            end
            pix = clamp_s32(pix + ((longint'(r.spread) * de) >>> COEF_BITS));
        end
        res.hit = 1'b1;
        res.steps = steps_max;
        res.travel = trav[POS_W-1:0];
        res.limit_flag = 1'b1;
        return res;
    endfunction

    function automatic ray_t mk_ray(input int ox, input int oy, input int oz,
                                    input int dx, input int dy, input int dz, input int spread);
        ray_t r;
        r.ox = ox;
        r.oy = oy;
        r.oz = oz;
        r.dx = DIR_W'(dx);
        r.dy = DIR_W'(dy);
        r.dz = DIR_W'(dz);
        r.spread = COEF_W'(spread);
        return r;
    endfunction

    function automatic int edge_pos();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 32'h00010000;
            2: return 32'hFFFF0000;
            3: return P_MAX;
            4: return P_MIN;
            5: return 32'h00010001;
            6: return 32'hFFFEFFFF;
            default: return 32'h00020000;
        endcase
    endfunction

    function automatic int edge_dir();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 65536;
            2: return -65536;
            3: return 1;
            4: return -1;
            5: return 131071;
            6: return -131072;
            default: return 32768;
        endcase
    endfunction

    // mostly aimed rays from a few units out, then raw noise and corner values
    function automatic ray_t random_ray();
        int  sel;
        int  o[3];
        int  t[3];
        int  d[3];
        int  spread;
        real v[3];
        real len;
        sel = $urandom_range(0, 99);
        if (sel < 70)
        begin
            for (int k = 0; k < 3; k++)
            begin
                o[k] = int'($urandom_range(0, 12 * 65536)) - 6 * 65536;
                t[k] = int'($urandom_range(0, 170394)) - 85197;
                v[k] = real'(t[k] - o[k]);
            end
            len = $sqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]);
            for (int k = 0; k < 3; k++)
            begin
                d[k] = (len < 1.0) ? 0 : $rtoi(v[k] / len * 65536.0);
            end
            sel = $urandom_range(0, 99);
            spread = (sel < 75) ? int'($urandom_range(16, 2048)) :
                     (sel < 85) ? 0 : int'($urandom_range(0, 65535));
            return mk_ray(o[0], o[1], o[2], d[0], d[1], d[2], spread);
        end
        else if (sel < 88)
        begin
            return mk_ray($urandom, $urandom, $urandom,
                          int'($urandom_range(0, 131072)) - 65536,
                          int'($urandom_range(0, 131072)) - 65536,
                          int'($urandom_range(0, 131072)) - 65536,
                          $urandom_range(0, 65535));
        end
        return mk_ray(edge_pos(), edge_pos(), edge_pos(), edge_dir(), edge_dir(), edge_dir(),
                      ($urandom_range(0, 1) == 1) ? 65535 : int'($urandom_range(0, 65535)));
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40)
        begin
            $display("mismatch on result %0d: %s", results_seen, msg);
        end
    endtask

    task automatic send_ray(input ray_t r);
        in_valid <= 1'b1;
        origin_x <= r.ox;
        origin_y <= r.oy;
        origin_z <= r.oz;
        dir_x <= r.dx;
        dir_y <= r.dy;
        dir_z <= r.dz;
        spread_coef <= r.spread;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        march_expect.push_back(predict_march(r, cfg_max_steps));
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 16);
            if (gap_max > 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge clk);
            end
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (march_expect.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_max_steps(input logic [STEP_W-1:0] v);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cfg_max_steps = v;
        @(posedge clk);
    endtask

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++)
        begin
            send_ray(random_ray());
        end
    endtask

    task automatic test_directed();
        stall_mode = 1;
        gap_max = 3;
        send_ray(mk_ray(0, 0, 0, 65536, 0, 0, 0));
        send_ray(mk_ray(65536, 0, 0, 65536, 0, 0, 0));
        send_ray(mk_ray(2 * 65536, 2 * 65536, 2 * 65536, 65536, 65536, 65536, 100));
        send_ray(mk_ray(-2 * 65536, -2 * 65536, -2 * 65536, -65536, -65536, -65536, 100));
        // zero components count as positive
        send_ray(mk_ray(2 * 65536, 0, 0, 65536, 0, 0, 0));
        send_ray(mk_ray(2 * 65536, 0, 0, 65536, -1, 0, 0));
        send_ray(mk_ray(-2 * 65536, 0, 0, 65536, 0, 0, 0));
        send_ray(mk_ray(0, 2 * 65536, 0, -65536, 0, 0, 0));
        send_ray(mk_ray(P_MAX, 0, 0, -65536, 0, 0, 0));
        send_ray(mk_ray(P_MIN, 0, 0, 65536, 0, 0, 65535));
        send_ray(mk_ray(P_MAX, P_MAX, P_MAX, -65536, -65536, -65536, 65535));
        send_ray(mk_ray(P_MIN, P_MAX, 0, 65536, -65536, 0, 0));
        send_ray(mk_ray(3 * 65536, 32768, 0, -65536, 0, 0, 65535));
        send_ray(mk_ray(-4 * 65536, 65536 + 7, 0, 65536, 0, 0, 0));
        send_ray(mk_ray(5 * 65536, 5 * 65536, 5 * 65536, -1, -1, -1, 0));
        send_ray(mk_ray(3 * 65536, 0, 0, -131072, 0, 0, 300));
        send_ray(mk_ray(0, -3 * 65536, 0, 0, 131071, 0, 65535));
        send_ray(mk_ray(-3 * 65536, 65536, 65536, 65536, -46341, 0, 1));
        send_ray(mk_ray(P_MIN, P_MIN, P_MIN, 65536, 65536, 65536, 65535));
        send_ray(mk_ray(1, -1, 65535, -65536, 65536, 0, 65535));
    endtask

    task automatic test_random_rays();
        for (int seg = 0; seg < 4; seg++)
        begin
            stall_mode = seg;
            gap_max = (seg == 0) ? 0 : 2 + 4 * seg;
            if (seg == 2)
            begin
                wait_drained();
            end
            run_random(148);
        end
    endtask

    task automatic test_single_step();
        write_max_steps(8'd1);
        stall_mode = 2;
        gap_max = 5;
        run_random(150);
    endtask

    task automatic test_zero_limit();
        write_max_steps(8'd0);
        stall_mode = 3;
        gap_max = 0;
        run_random(40);
    endtask

    task automatic test_full_limit();
        write_max_steps(8'd255);
        stall_mode = 1;
        gap_max = 8;
        run_random(120);
    endtask

    task automatic test_random_limits();
        for (int ph = 0; ph < 3; ph++)
        begin
            write_max_steps((ph == 2) ? STEP_W'($urandom_range(41, 254)) :
                                        STEP_W'($urandom_range(2, 40)));
            stall_mode = ph + 1;
            gap_max = 2 * ph;
            run_random(60);
        end
    endtask

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (march_expect.size() == 0)
            begin
                report_mismatch("result with nothing expected");
            end
            else
            begin
                want_res = march_expect.pop_front();
                if (hit !== want_res.hit)
                begin
                    report_mismatch($sformatf("hit %b, expected %b", hit, want_res.hit));
                end
                if (steps_taken !== want_res.steps)
                begin
                    report_mismatch($sformatf("steps_taken %0d, expected %0d",
                                              steps_taken, want_res.steps));
                end
                if (travel_dist !== want_res.travel)
                begin
                    report_mismatch($sformatf("travel_dist %0d, expected %0d",
                                              travel_dist, want_res.travel));
                end
                if (limit_reached !== want_res.limit_flag)
                begin
                    report_mismatch($sformatf("limit_reached %b, expected %b",
                                              limit_reached, want_res.limit_flag));
                end
            end
        end
        case (stall_mode)
            1: out_stall <= ($urandom_range(0, 99) < 35);
            2: out_stall <= ((cycle_cnt % 5) >= 3);
            3:
            begin
                if (stall_hold > 0)
                begin
                    stall_hold--;
                end
                else if ($urandom_range(0, 99) < 5)
                begin
                    stall_hold = $urandom_range(5, 30);
                end
                out_stall <= (stall_hold > 0);
            end
            default: out_stall <= 1'b0;
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles", quiet_cycles);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        in_valid <= 1'b0;
        origin_x <= '0;
        origin_y <= '0;
        origin_z <= '0;
        dir_x <= '0;
        dir_y <= '0;
        dir_z <= '0;
        spread_coef <= '0;
        out_stall <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_rays();
        test_single_step();
        test_zero_limit();
        test_full_limit();
        test_random_limits();
        wait_drained();
        repeat (MARCH_CYCLES_MAX + 16) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
